>>> hdl/tfn_pkg.sv
// Package with widths and the cell bus type for the triangle facet normal pipeline.
package tfn_pkg;

	localparam int CW  = 16;
	localparam int EW  = 17;
	localparam int PW  = 34;
	localparam int NW  = 35;
	localparam int AW  = 34;
	localparam int HW  = 17;
	localparam int SQW = 68;
	localparam int SW  = 70;
	localparam int WW  = 128;
	localparam int QW  = 15;
	localparam int NCELL = 15;
	localparam logic [CW-1:0] Q14_ONE = 16'd16384;

	typedef struct packed {
		logic [SW-1:0]         s;
		logic [2:0][WW-1:0]    e;
		logic [2:0][WW-1:0]    r;
		logic [2:0][QW-1:0]    q;
		logic [2:0]            neg;
		logic                  degen;
	} cell_bus_t;

endpackage

>>> hdl/tfn_if.sv
// Stream interfaces for triangle beats in and normal beats out.
interface tfn_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
	modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tfn_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic               degenerate;
	modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

>>> hdl/tfn_front.sv
// Front pipeline: edges, cross product, squared length and start values of the search.
module tfn_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [15:0]      ax, ay, az, bx, by, bz, cx, cy, cz,
	output logic                    out_valid,
	output tfn_pkg::cell_bus_t      bus
);
	import tfn_pkg::*;

	logic [6:0] v_q;

	logic signed [EW-1:0] u_s1 [3];
	logic signed [EW-1:0] w_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic [AW-1:0]        a_s3 [3];
	logic [2:0]           neg_s3;
	logic                 degen_s3;
	logic [PW-1:0]        hh_s4 [3];
	logic [PW-1:0]        hl_s4 [3];
	logic [PW-1:0]        ll_s4 [3];
	logic [2:0]           neg_s4;
	logic                 degen_s4;
	logic [SQW-1:0]       sq_s5 [3];
	logic [2:0]           neg_s5;
	logic                 degen_s5;
	logic [SQW-1:0]       sq_s6 [3];
	logic [SW-1:0]        s_s6;
	logic [2:0]           neg_s6;
	logic                 degen_s6;

	logic signed [NW-1:0] n_c [3];

	always_comb begin
		n_c[0] = NW'(p_s2[0]) - NW'(p_s2[1]);
		n_c[1] = NW'(p_s2[2]) - NW'(p_s2[3]);
		n_c[2] = NW'(p_s2[4]) - NW'(p_s2[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= EW'(bx) - EW'(ax);
			u_s1[1] <= EW'(by) - EW'(ay);
			u_s1[2] <= EW'(bz) - EW'(az);
			w_s1[0] <= EW'(cx) - EW'(ax);
			w_s1[1] <= EW'(cy) - EW'(ay);
			w_s1[2] <= EW'(cz) - EW'(az);

			p_s2[0] <= u_s1[1] * w_s1[2];
			p_s2[1] <= u_s1[2] * w_s1[1];
			p_s2[2] <= u_s1[2] * w_s1[0];
			p_s2[3] <= u_s1[0] * w_s1[2];
			p_s2[4] <= u_s1[0] * w_s1[1];
			p_s2[5] <= u_s1[1] * w_s1[0];

			for (int k = 0; k < 3; k++) begin
				neg_s3[k] <= n_c[k][NW-1];
				a_s3[k]   <= n_c[k][NW-1] ? AW'(-n_c[k]) : AW'(n_c[k]);
			end
			degen_s3 <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);

			for (int k = 0; k < 3; k++) begin
				hh_s4[k] <= PW'(a_s3[k][AW-1:HW]) * PW'(a_s3[k][AW-1:HW]);
				hl_s4[k] <= PW'(a_s3[k][AW-1:HW]) * PW'(a_s3[k][HW-1:0]);
				ll_s4[k] <= PW'(a_s3[k][HW-1:0]) * PW'(a_s3[k][HW-1:0]);
			end
			neg_s4   <= neg_s3;
			degen_s4 <= degen_s3;

			for (int k = 0; k < 3; k++) begin
				sq_s5[k] <= (SQW'(hh_s4[k]) << (2 * HW)) + (SQW'(hl_s4[k]) << (HW + 1))
					+ SQW'(ll_s4[k]);
			end
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;

			sq_s6    <= sq_s5;
			s_s6     <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;

			bus.s <= s_s6;
			for (int k = 0; k < 3; k++) begin
				bus.e[k] <= (WW'(sq_s6[k]) << 30) - WW'(s_s6);
				bus.r[k] <= WW'(0) - (WW'(s_s6) << 16);
				bus.q[k] <= '0;
			end
			bus.neg   <= neg_s6;
			bus.degen <= degen_s6;
		end
	end

	assign out_valid = v_q[6];

endmodule

>>> hdl/tfn_cell.sv
// One cell of the rounding search: decides one result bit for all three components.
module tfn_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tfn_pkg::cell_bus_t  bus_in,
	output logic                out_valid,
	output tfn_pkg::cell_bus_t  bus_out
);
	import tfn_pkg::*;

	logic [WW-1:0] s30, s31;
	logic signed [WW-1:0] d [3];
	logic [2:0] take;
	cell_bus_t nxt;

	always_comb begin
		s30 = WW'(bus_in.s) << 30;
		s31 = WW'(bus_in.s) << 31;
		nxt = bus_in;
		for (int k = 0; k < 3; k++) begin
			d[k]    = $signed(bus_in.r[k]) + $signed(s30);
			take[k] = d[k] <= $signed(bus_in.e[k]);
			if (take[k]) begin
				nxt.e[k] = (bus_in.e[k] - d[k]) << 2;
				nxt.r[k] = (bus_in.r[k] + s31) << 1;
			end else begin
				nxt.e[k] = bus_in.e[k] << 2;
				nxt.r[k] = bus_in.r[k] << 1;
			end
			nxt.q[k] = {bus_in.q[k][QW-2:0], take[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_out <= nxt;
		end
	end

endmodule

>>> hdl/triangle_facet_normal.sv
// Top level of the triangle facet normal block.
// The vert channel carries one triangle per beat: three vertices ax..cz, signed Q8.8.
// The normal channel returns one beat per triangle: norm_x, norm_y, norm_z in signed
// Q1.14, rounded to nearest, and degenerate, which is set when the cross product is
// zero and the fallback normal (0, 0, 1) is returned.
// The block is a single pipeline: seven front stages form the edges, the cross product
// and the squared length, then a chain of fifteen search cells decides one bit of each
// component per cell, and an output register applies signs and the fallback.
// A new triangle is accepted every cycle while the output side takes beats.
// When the receiver stalls with a beat waiting, the whole pipeline holds and vert.ready
// drops in the same cycle; no beat is lost or repeated.
// Reset clears all valid flags, so the pipeline starts empty and accepts at once.
// Nothing is kept from one triangle to the next.
module triangle_facet_normal (
	input  logic       clk,
	input  logic       arst_n,
	tfn_in_if.sink     vert,
	tfn_out_if.source  normal
);
	import tfn_pkg::*;

	logic      en;
	logic      front_valid;
	cell_bus_t chain_bus [NCELL+1];
	logic      chain_v [NCELL+1];
	logic      out_v_q;
	logic signed [CW-1:0] nx_q, ny_q, nz_q;
	logic      degen_q;

	assign en = !out_v_q || normal.ready;
	assign vert.ready = en;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vert.valid),
		.ax        (vert.ax), .ay (vert.ay), .az (vert.az),
		.bx        (vert.bx), .by (vert.by), .bz (vert.bz),
		.cx        (vert.cx), .cy (vert.cy), .cz (vert.cz),
		.out_valid (front_valid),
		.bus       (chain_bus[0])
	);

	assign chain_v[0] = front_valid;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		tfn_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[i]),
			.bus_in    (chain_bus[i]),
			.out_valid (chain_v[i+1]),
			.bus_out   (chain_bus[i+1])
		);
	end

	function automatic logic signed [CW-1:0] apply_sign(logic [QW-1:0] q, logic neg);
		logic signed [CW-1:0] m;
		m = $signed(CW'(q));
		return neg ? -m : m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= chain_v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= chain_bus[NCELL].degen;
			if (chain_bus[NCELL].degen) begin
				nx_q <= '0;
				ny_q <= '0;
				nz_q <= $signed(Q14_ONE);
			end else begin
				nx_q <= apply_sign(chain_bus[NCELL].q[0], chain_bus[NCELL].neg[0]);
				ny_q <= apply_sign(chain_bus[NCELL].q[1], chain_bus[NCELL].neg[1]);
				nz_q <= apply_sign(chain_bus[NCELL].q[2], chain_bus[NCELL].neg[2]);
			end
		end
	end

	assign normal.valid      = out_v_q;
	assign normal.norm_x     = nx_q;
	assign normal.norm_y     = ny_q;
	assign normal.norm_z     = nz_q;
	assign normal.degenerate = degen_q;

	a_degen_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && degen_q |-> nx_q == '0 && ny_q == '0 && nz_q == $signed(Q14_ONE))
		else $error("degenerate beat without fallback normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> nx_q <= $signed(Q14_ONE) && nx_q >= -$signed(Q14_ONE)
			&& nz_q <= $signed(Q14_ONE) && nz_q >= -$signed(Q14_ONE))
		else $error("normal component out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !normal.ready |=> out_v_q && $stable(nx_q) && $stable(chain_v[NCELL]))
		else $error("pipeline moved during stall");

endmodule
